// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is active.
`define AFK_ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define AFK_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/afk_pkg.sv =====
// ----------------------------------------------------------------------------
// afk_pkg
// Types, constants and arithmetic helpers for the arm forward kinematics.
// ----------------------------------------------------------------------------
package afk_pkg;

    localparam int NUM_ANGLES = 5;
    localparam int TABLE_LEN  = 24;
    localparam int XY_W       = 34;
    localparam int Z_W        = 32;
    localparam int TRIG_W     = 16;
    localparam int LEN_W      = 16;
    localparam int TIP_W      = 24;
    localparam int VEC_W      = 16;
    localparam int ADDR_W     = 5;
    localparam int DATA_W     = 32;

    // lane order inside the CORDIC chain
    localparam int LANE_T1  = 0;
    localparam int LANE_T2  = 1;
    localparam int LANE_T23 = 2;
    localparam int LANE_T4  = 3;
    localparam int LANE_T5  = 4;

    localparam logic signed [17:0] FULL_TURN    = 18'sd46080;
    localparam logic [15:0]        QUARTER_1    = 16'd11520;
    localparam logic [15:0]        QUARTER_2    = 16'd23040;
    localparam logic [15:0]        QUARTER_3    = 16'd34560;
    localparam logic signed [XY_W-1:0] CORDIC_X0 = 34'sd652032874;
    localparam logic signed [TRIG_W-1:0] ONE_Q14 = 16'sd16384;

    // atan(2^-i) in 2^-20 degree
    localparam logic signed [Z_W-1:0] ATAN_DEG20 [TABLE_LEN] = '{
        32'sd47185920, 32'sd27855475, 32'sd14718068, 32'sd7471121,
        32'sd3750058,  32'sd1876857,  32'sd938658,   32'sd469357,
        32'sd234682,   32'sd117342,   32'sd58671,    32'sd29335,
        32'sd14668,    32'sd7334,     32'sd3667,     32'sd1833,
        32'sd917,      32'sd458,      32'sd229,      32'sd115,
        32'sd57,       32'sd29,       32'sd14,       32'sd7
    };

    typedef enum logic [2:0] {
        REG_D2 = 3'd0,
        REG_A2 = 3'd1,
        REG_A3 = 3'd2,
        REG_D4 = 3'd3,
        REG_D6 = 3'd4
    } reg_idx_t;

    localparam logic signed [LEN_W-1:0] RST_D2 = 16'sd461;
    localparam logic signed [LEN_W-1:0] RST_A2 = 16'sd845;
    localparam logic signed [LEN_W-1:0] RST_A3 = 16'sd0;
    localparam logic signed [LEN_W-1:0] RST_D4 = 16'sd845;
    localparam logic signed [LEN_W-1:0] RST_D6 = 16'sd256;

    typedef struct packed {
        logic signed [15:0] joint_one;
        logic signed [15:0] joint_two;
        logic signed [15:0] joint_three;
        logic signed [15:0] joint_four;
        logic signed [15:0] joint_five;
    } joint_t;

    typedef struct packed {
        logic signed [TIP_W-1:0] tip_x;
        logic signed [TIP_W-1:0] tip_y;
        logic signed [TIP_W-1:0] tip_z;
        logic signed [VEC_W-1:0] approach_x;
        logic signed [VEC_W-1:0] approach_y;
        logic signed [VEC_W-1:0] approach_z;
    } pose_t;

    typedef struct packed {
        logic signed [LEN_W-1:0] d2;
        logic signed [LEN_W-1:0] a2;
        logic signed [LEN_W-1:0] a3;
        logic signed [LEN_W-1:0] d4;
        logic signed [LEN_W-1:0] d6;
    } cfg_t;

    typedef struct packed {
        logic signed [TRIG_W-1:0] s1;
        logic signed [TRIG_W-1:0] c1;
        logic signed [TRIG_W-1:0] s2;
        logic signed [TRIG_W-1:0] c2;
        logic signed [TRIG_W-1:0] s23;
        logic signed [TRIG_W-1:0] c23;
        logic signed [TRIG_W-1:0] s4;
        logic signed [TRIG_W-1:0] c4;
        logic signed [TRIG_W-1:0] s5;
        logic signed [TRIG_W-1:0] c5;
    } trig_t;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic [1:0]             q;
    } lane_t;

    typedef lane_t [NUM_ANGLES-1:0] lanes_t;

    // wrap to one turn, split off the quadrant, load the CORDIC start vector
    function automatic lane_t lane_init(input logic signed [16:0] a);
        logic signed [17:0] ax;
        logic signed [17:0] r;
        logic [15:0]        ru;
        logic [13:0]        rest;
        lane_t              ln;
        ax = 18'(a);
        priority if (ax < -FULL_TURN)
            r = ax + FULL_TURN + FULL_TURN;
        else if (ax < 18'sd0)
            r = ax + FULL_TURN;
        else if (ax >= FULL_TURN)
            r = ax - FULL_TURN;
        else
            r = ax;
        ru = r[15:0];
        priority if (ru >= QUARTER_3) begin
            ln.q = 2'd3;
            rest = 14'(ru - QUARTER_3);
        end
        else if (ru >= QUARTER_2) begin
            ln.q = 2'd2;
            rest = 14'(ru - QUARTER_2);
        end
        else if (ru >= QUARTER_1) begin
            ln.q = 2'd1;
            rest = 14'(ru - QUARTER_1);
        end
        else begin
            ln.q = 2'd0;
            rest = ru[13:0];
        end
        ln.x = CORDIC_X0;
        ln.y = '0;
        ln.z = Z_W'({rest, 13'b0});
        return ln;
    endfunction

    // Q1.30 to Q1.14, half up, clamped to +/-1
    function automatic logic signed [TRIG_W-1:0] trig_round(input logic signed [XY_W-1:0] v);
        logic signed [XY_W-1:0] t;
        t = (v + 34'sd32768) >>> 16;
        if (t > 34'sd16384)
            return ONE_Q14;
        else if (t < -34'sd16384)
            return -ONE_Q14;
        else
            return TRIG_W'(t);
    endfunction

    function automatic logic signed [63:0] round_shift(input logic signed [63:0] v,
                                                       input int unsigned s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic logic signed [TIP_W-1:0] sat_tip(input logic signed [63:0] v);
        if (v > 64'sd8388607)
            return 24'sd8388607;
        else if (v < -64'sd8388608)
            return -24'sd8388608;
        else
            return TIP_W'(v);
    endfunction

    function automatic logic signed [VEC_W-1:0] sat_vec(input logic signed [63:0] v);
        if (v > 64'sd16384)
            return ONE_Q14;
        else if (v < -64'sd16384)
            return -ONE_Q14;
        else
            return VEC_W'(v);
    endfunction

endpackage

// ===== design/arm_forward_kinematics_top.sv =====
// ----------------------------------------------------------------------------
// arm_forward_kinematics_top
// Forward kinematics of a six-axis arm: joint angles in, tip pose out.
// ----------------------------------------------------------------------------
// Joint channel: joint_valid/joint_ready carry five angles in 1/128 degree.
// Pose channel: pose_valid/pose_ready carry the Q16.8 tip position and the
// Q1.14 approach vector, saturated.
// One transaction per cycle is accepted while the pose output is not stalled.
// The path holds CORDIC_STAGES + 10 register stages: angle wrap, one CORDIC
// cell per stage, quadrant fix-up, then seven multiply/sum stages and the
// output register.
// The whole pipeline advances as one; when pose_valid is high and pose_ready
// low, every stage holds and joint_ready drops in the same cycle.
// Reset clears all valid bits and loads the link lengths with their defaults
// (d2 461, a2 845, a3 0, d4 845, d6 256 in Q8.8).
// Lengths sit at APB byte addresses 0, 4, 8, 12, 16; write them only while no
// transaction is in flight.
// ----------------------------------------------------------------------------
module arm_forward_kinematics_top
    import afk_pkg::*;
#(
    parameter int CORDIC_STAGES = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              joint_valid,
    output logic              joint_ready,
    input  joint_t            joint_data,
    output logic              pose_valid,
    input  logic              pose_ready,
    output pose_t             pose_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    cfg_t     cfg_reg;
    logic     adv;
    logic     trig_valid;
    trig_t    trig;
    reg_idx_t reg_idx;

    assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.d2 <= RST_D2;
            cfg_reg.a2 <= RST_A2;
            cfg_reg.a3 <= RST_A3;
            cfg_reg.d4 <= RST_D4;
            cfg_reg.d6 <= RST_D6;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (reg_idx)
                REG_D2:  cfg_reg.d2 <= $signed(pwdata[LEN_W-1:0]);
                REG_A2:  cfg_reg.a2 <= $signed(pwdata[LEN_W-1:0]);
                REG_A3:  cfg_reg.a3 <= $signed(pwdata[LEN_W-1:0]);
                REG_D4:  cfg_reg.d4 <= $signed(pwdata[LEN_W-1:0]);
                REG_D6:  cfg_reg.d6 <= $signed(pwdata[LEN_W-1:0]);
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_D2:  prdata = {{(DATA_W-LEN_W){1'b0}}, cfg_reg.d2};
            REG_A2:  prdata = {{(DATA_W-LEN_W){1'b0}}, cfg_reg.a2};
            REG_A3:  prdata = {{(DATA_W-LEN_W){1'b0}}, cfg_reg.a3};
            REG_D4:  prdata = {{(DATA_W-LEN_W){1'b0}}, cfg_reg.d4};
            REG_D6:  prdata = {{(DATA_W-LEN_W){1'b0}}, cfg_reg.d6};
            default: prdata = '0;
        endcase
    end

    // global advance: the output register is free or being emptied
    assign adv         = !pose_valid || pose_ready;
    assign joint_ready = adv;

    afk_sincos #(
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_sincos (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (joint_valid),
        .joints    (joint_data),
        .out_valid (trig_valid),
        .trig      (trig)
    );

    afk_kin u_kin (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (trig_valid),
        .trig      (trig),
        .cfg       (cfg_reg),
        .out_valid (pose_valid),
        .pose      (pose_data)
    );

endmodule

// ===== design/afk_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// afk_cordic_cell
// One CORDIC micro-rotation for all angle lanes, registered.
// ----------------------------------------------------------------------------
module afk_cordic_cell
    import afk_pkg::*;
#(
    parameter int STAGE = 0
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   en,
    input  logic   in_valid,
    input  lanes_t in_lanes,
    output logic   out_valid,
    output lanes_t out_lanes
);

    logic   valid_reg;
    lanes_t lanes_reg;
    lanes_t lanes_next;

    always_comb
    begin
        logic signed [XY_W-1:0] dx;
        logic signed [XY_W-1:0] dy;
        lanes_next = in_lanes;
        for (int i = 0; i < NUM_ANGLES; i++)
        begin
            dx = in_lanes[i].y >>> STAGE;
            dy = in_lanes[i].x >>> STAGE;
            if (!in_lanes[i].z[Z_W-1])
            begin
                lanes_next[i].x = in_lanes[i].x - dx;
                lanes_next[i].y = in_lanes[i].y + dy;
                lanes_next[i].z = in_lanes[i].z - ATAN_DEG20[STAGE];
            end
            else
            begin
                lanes_next[i].x = in_lanes[i].x + dx;
                lanes_next[i].y = in_lanes[i].y - dy;
                lanes_next[i].z = in_lanes[i].z + ATAN_DEG20[STAGE];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            lanes_reg <= lanes_next;
    end

    assign out_valid = valid_reg;
    assign out_lanes = lanes_reg;

endmodule

// ===== design/afk_sincos.sv =====
// ----------------------------------------------------------------------------
// afk_sincos
// Angle wrap, CORDIC cell chain and quadrant fix-up for the five sin/cos pairs.
// ----------------------------------------------------------------------------
module afk_sincos
    import afk_pkg::*;
#(
    parameter int CORDIC_STAGES = 16
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   en,
    input  logic   in_valid,
    input  joint_t joints,
    output logic   out_valid,
    output trig_t  trig
);

    lanes_t chain_lanes [CORDIC_STAGES+1];
    logic   chain_valid [CORDIC_STAGES+1];

    logic   pre_valid_reg;
    lanes_t pre_lanes_reg;
    lanes_t pre_lanes_next;
    logic   post_valid_reg;
    trig_t  trig_reg;
    trig_t  trig_next;

    always_comb
    begin
        pre_lanes_next[LANE_T1]  = lane_init(17'(joints.joint_one));
        pre_lanes_next[LANE_T2]  = lane_init(17'(joints.joint_two));
        pre_lanes_next[LANE_T23] = lane_init(17'(joints.joint_two) + 17'(joints.joint_three));
        pre_lanes_next[LANE_T4]  = lane_init(17'(joints.joint_four));
        pre_lanes_next[LANE_T5]  = lane_init(17'(joints.joint_five));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_valid_reg  <= 1'b0;
            post_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            pre_valid_reg  <= in_valid;
            post_valid_reg <= chain_valid[CORDIC_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pre_lanes_reg <= pre_lanes_next;
            trig_reg      <= trig_next;
        end
    end

    assign chain_lanes[0] = pre_lanes_reg;
    assign chain_valid[0] = pre_valid_reg;

    for (genvar g = 0; g < CORDIC_STAGES; g++)
    begin : g_cell
        afk_cordic_cell #(
            .STAGE (g)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (chain_valid[g]),
            .in_lanes  (chain_lanes[g]),
            .out_valid (chain_valid[g+1]),
            .out_lanes (chain_lanes[g+1])
        );
    end

    // rotate the first-quadrant result back into the angle's quadrant
    always_comb
    begin
        logic signed [TRIG_W-1:0] c;
        logic signed [TRIG_W-1:0] s;
        logic signed [TRIG_W-1:0] sn [NUM_ANGLES];
        logic signed [TRIG_W-1:0] cs [NUM_ANGLES];
        for (int i = 0; i < NUM_ANGLES; i++)
        begin
            c = trig_round(chain_lanes[CORDIC_STAGES][i].x);
            s = trig_round(chain_lanes[CORDIC_STAGES][i].y);
            unique case (chain_lanes[CORDIC_STAGES][i].q)
                2'd0:
                begin
                    cs[i] = c;
                    sn[i] = s;
                end
                2'd1:
                begin
                    cs[i] = -s;
                    sn[i] = c;
                end
                2'd2:
                begin
                    cs[i] = -c;
                    sn[i] = -s;
                end
                default:
                begin
                    cs[i] = s;
                    sn[i] = -c;
                end
            endcase
        end
        trig_next.s1  = sn[LANE_T1];
        trig_next.c1  = cs[LANE_T1];
        trig_next.s2  = sn[LANE_T2];
        trig_next.c2  = cs[LANE_T2];
        trig_next.s23 = sn[LANE_T23];
        trig_next.c23 = cs[LANE_T23];
        trig_next.s4  = sn[LANE_T4];
        trig_next.c4  = cs[LANE_T4];
        trig_next.s5  = sn[LANE_T5];
        trig_next.c5  = cs[LANE_T5];
    end

    assign out_valid = post_valid_reg;
    assign trig      = trig_reg;

endmodule

// ===== design/afk_kin.sv =====
// ----------------------------------------------------------------------------
// afk_kin
// Pipelined closed-form position and approach vector from sin/cos terms.
// ----------------------------------------------------------------------------
module afk_kin
    import afk_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  logic  in_valid,
    input  trig_t trig,
    input  cfg_t  cfg,
    output logic  out_valid,
    output pose_t pose
);

    localparam int NUM_STAGES = 8;

    logic [NUM_STAGES-1:0] vld_reg;

    // stage 1
    logic signed [29:0] s45_1_reg, c4s5_1_reg, c23c5_1_reg, s23c5_1_reg;
    logic signed [31:0] pa_1_reg, pb_1_reg, pc_1_reg, pd_1_reg, pe_1_reg, pf_1_reg;
    logic signed [15:0] c1_1_reg, s1_1_reg, c23_1_reg, s23_1_reg;
    // stage 2
    logic signed [46:0] w42_2_reg, v42_2_reg;
    logic signed [45:0] gp_2_reg;
    logic signed [33:0] hs_2_reg, zs_2_reg;
    logic signed [29:0] s45_2_reg;
    logic signed [15:0] c1_2_reg, s1_2_reg;
    // stage 3
    logic signed [32:0] w28_3_reg, v28_3_reg;
    logic signed [15:0] az_3_reg;
    logic signed [45:0] g_3_reg;
    logic signed [33:0] hs_3_reg, zs_3_reg;
    logic signed [29:0] s45_3_reg;
    logic signed [15:0] c1_3_reg, s1_3_reg;
    // stage 4
    logic signed [49:0] axp_4_reg, ayp_4_reg, hp_4_reg, zp_4_reg;
    logic signed [45:0] g_4_reg;
    logic signed [33:0] hs_4_reg, zs_4_reg;
    logic signed [15:0] az_4_reg, c1_4_reg, s1_4_reg;
    // stage 5
    logic signed [49:0] h_5_reg, pz_5_reg;
    logic signed [45:0] g_5_reg;
    logic signed [15:0] ax_5_reg, ay_5_reg, az_5_reg, c1_5_reg, s1_5_reg;
    // stage 6: partial products of the wide position terms
    logic signed [41:0] c1hh_6_reg, c1hl_6_reg, s1hh_6_reg, s1hl_6_reg;
    logic signed [41:0] c1gh_6_reg, c1gl_6_reg, s1gh_6_reg, s1gl_6_reg;
    logic signed [23:0] tz_6_reg;
    logic signed [15:0] ax_6_reg, ay_6_reg, az_6_reg;
    // stage 7
    logic signed [63:0] px_7_reg, py_7_reg;
    logic signed [23:0] tz_7_reg;
    logic signed [15:0] ax_7_reg, ay_7_reg, az_7_reg;
    // stage 8
    pose_t pose_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NUM_STAGES-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s45_1_reg   <= 30'(trig.s4) * 30'(trig.s5);
            c4s5_1_reg  <= 30'(trig.c4) * 30'(trig.s5);
            c23c5_1_reg <= 30'(trig.c23) * 30'(trig.c5);
            s23c5_1_reg <= 30'(trig.s23) * 30'(trig.c5);
            pa_1_reg    <= 32'(trig.s23) * 32'(cfg.d4);
            pb_1_reg    <= 32'(cfg.a3) * 32'(trig.c23);
            pc_1_reg    <= 32'(cfg.a2) * 32'(trig.c2);
            pd_1_reg    <= 32'(trig.c23) * 32'(cfg.d4);
            pe_1_reg    <= 32'(cfg.a3) * 32'(trig.s23);
            pf_1_reg    <= 32'(cfg.a2) * 32'(trig.s2);
            c1_1_reg    <= trig.c1;
            s1_1_reg    <= trig.s1;
            c23_1_reg   <= trig.c23;
            s23_1_reg   <= trig.s23;

            w42_2_reg <= 47'(c23_1_reg) * 47'(c4s5_1_reg) + (47'(s23c5_1_reg) <<< 14);
            v42_2_reg <= (47'(c23c5_1_reg) <<< 14) - 47'(s23_1_reg) * 47'(c4s5_1_reg);
            gp_2_reg  <= 46'(cfg.d6) * 46'(s45_1_reg);
            hs_2_reg  <= 34'(pa_1_reg) + 34'(pb_1_reg) + 34'(pc_1_reg);
            zs_2_reg  <= 34'(pd_1_reg) - 34'(pe_1_reg) - 34'(pf_1_reg);
            s45_2_reg <= s45_1_reg;
            c1_2_reg  <= c1_1_reg;
            s1_2_reg  <= s1_1_reg;

            w28_3_reg <= 33'((w42_2_reg + 47'sd8192) >>> 14);
            v28_3_reg <= 33'((v42_2_reg + 47'sd8192) >>> 14);
            az_3_reg  <= sat_vec(round_shift(64'(v42_2_reg), 28));
            g_3_reg   <= gp_2_reg + (46'(cfg.d2) <<< 28);
            hs_3_reg  <= hs_2_reg;
            zs_3_reg  <= zs_2_reg;
            s45_3_reg <= s45_2_reg;
            c1_3_reg  <= c1_2_reg;
            s1_3_reg  <= s1_2_reg;

            axp_4_reg <= 50'(c1_3_reg) * 50'(w28_3_reg) - 50'(s1_3_reg) * 50'(s45_3_reg);
            ayp_4_reg <= 50'(s1_3_reg) * 50'(w28_3_reg) + 50'(c1_3_reg) * 50'(s45_3_reg);
            hp_4_reg  <= 50'(cfg.d6) * 50'(w28_3_reg);
            zp_4_reg  <= 50'(cfg.d6) * 50'(v28_3_reg);
            g_4_reg   <= g_3_reg;
            hs_4_reg  <= hs_3_reg;
            zs_4_reg  <= zs_3_reg;
            az_4_reg  <= az_3_reg;
            c1_4_reg  <= c1_3_reg;
            s1_4_reg  <= s1_3_reg;

            h_5_reg  <= hp_4_reg + (50'(hs_4_reg) <<< 14);
            pz_5_reg <= zp_4_reg + (50'(zs_4_reg) <<< 14);
            g_5_reg  <= g_4_reg;
            ax_5_reg <= sat_vec(round_shift(64'(axp_4_reg), 28));
            ay_5_reg <= sat_vec(round_shift(64'(ayp_4_reg), 28));
            az_5_reg <= az_4_reg;
            c1_5_reg <= c1_4_reg;
            s1_5_reg <= s1_4_reg;

            // split h and g at bit 25: high part signed, low part unsigned
            c1hh_6_reg <= 42'(c1_5_reg) * 42'($signed(h_5_reg[49:25]));
            c1hl_6_reg <= 42'(c1_5_reg) * 42'($signed({1'b0, h_5_reg[24:0]}));
            s1hh_6_reg <= 42'(s1_5_reg) * 42'($signed(h_5_reg[49:25]));
            s1hl_6_reg <= 42'(s1_5_reg) * 42'($signed({1'b0, h_5_reg[24:0]}));
            c1gh_6_reg <= 42'(c1_5_reg) * 42'($signed(g_5_reg[45:25]));
            c1gl_6_reg <= 42'(c1_5_reg) * 42'($signed({1'b0, g_5_reg[24:0]}));
            s1gh_6_reg <= 42'(s1_5_reg) * 42'($signed(g_5_reg[45:25]));
            s1gl_6_reg <= 42'(s1_5_reg) * 42'($signed({1'b0, g_5_reg[24:0]}));
            tz_6_reg   <= sat_tip(round_shift(64'(pz_5_reg), 28));
            ax_6_reg   <= ax_5_reg;
            ay_6_reg   <= ay_5_reg;
            az_6_reg   <= az_5_reg;

            px_7_reg <= ((64'(c1hh_6_reg) - 64'(s1gh_6_reg)) <<< 25)
                        + 64'(c1hl_6_reg) - 64'(s1gl_6_reg);
            py_7_reg <= ((64'(s1hh_6_reg) + 64'(c1gh_6_reg)) <<< 25)
                        + 64'(s1hl_6_reg) + 64'(c1gl_6_reg);
            tz_7_reg <= tz_6_reg;
            ax_7_reg <= ax_6_reg;
            ay_7_reg <= ay_6_reg;
            az_7_reg <= az_6_reg;

            pose_reg.tip_x      <= sat_tip(round_shift(px_7_reg, 42));
            pose_reg.tip_y      <= sat_tip(round_shift(py_7_reg, 42));
            pose_reg.tip_z      <= tz_7_reg;
            pose_reg.approach_x <= ax_7_reg;
            pose_reg.approach_y <= ay_7_reg;
            pose_reg.approach_z <= az_7_reg;
        end
    end

    assign out_valid = vld_reg[NUM_STAGES-1];
    assign pose      = pose_reg;

endmodule

// ===== design/afk_checker.sv =====
// ----------------------------------------------------------------------------
// afk_checker
// Port-level checks on the forward kinematics top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module afk_checker
    import afk_pkg::*;
(
    input logic  clk,
    input logic  rst_n,
    input logic  joint_ready,
    input logic  pose_valid,
    input logic  pose_ready,
    input pose_t pose_data
);

    logic stalled;
    logic vec_ok;

    assign stalled = pose_valid && !pose_ready;
    assign vec_ok  = pose_data.approach_x >= -ONE_Q14 && pose_data.approach_x <= ONE_Q14
                  && pose_data.approach_y >= -ONE_Q14 && pose_data.approach_y <= ONE_Q14
                  && pose_data.approach_z >= -ONE_Q14 && pose_data.approach_z <= ONE_Q14;

    `AFK_ASSERT_ALWAYS(a_rst_no_pose, !rst_n |-> !pose_valid, "pose valid during reset")

    `AFK_ASSERT_CLK(a_pose_hold, stalled |=> pose_valid && $stable(pose_data), "stalled pose changed")

    // intake follows the output register: stall and accept together
    `AFK_ASSERT_CLK(a_flow, joint_ready == (!pose_valid || pose_ready), "joint_ready out of step")

    `AFK_ASSERT_CLK(a_vec_range, pose_valid |-> vec_ok, "approach vector beyond unit range")

endmodule

bind arm_forward_kinematics_top afk_checker u_afk_checker (.*);
